[src/vehicle_message_char_parser_assert.svh]
// Assertion macros shared by the vehicle message parser modules.
`ifndef VEHICLE_MESSAGE_CHAR_PARSER_ASSERT_SVH
`define VEHICLE_MESSAGE_CHAR_PARSER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define VMCP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define VMCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/vmcp_pkg.sv]
// Shared constants, types and functions of the vehicle message parser.
package vmcp_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int OUT_W          = 32;
    localparam int STATUS_W       = 3;
    localparam int KIND_W         = 3;
    localparam int SLOT_W         = 3;
    localparam int NUM_SLOTS      = 7;

    // Store slot order
    localparam logic [SLOT_W-1:0] SLOT_NUMBER = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_SPEED  = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_ANGLE  = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_BEAR   = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_EAST   = 3'd4;
    localparam logic [SLOT_W-1:0] SLOT_NORTH  = 3'd5;
    localparam logic [SLOT_W-1:0] SLOT_PROB   = 3'd6;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_SUCCESS   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_TYPE  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_INVAL     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_BAD_BRACE = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_BAD_ATTR  = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_BAD_NUM   = 3'd6;

    // Message kinds
    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DRIVE   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SENSOR  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_GOAL    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SEGMENT = 3'd4;

    // Characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UP_D   = 8'h44;
    localparam logic [7:0] CH_UP_G   = 8'h47;
    localparam logic [7:0] CH_UP_S   = 8'h53;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_P   = 8'h70;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_S   = 8'h73;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Field store update for one character
    typedef struct packed {
        logic                 clear_all;
        logic [NUM_SLOTS-1:0] zero_mask;
        logic                 digit_en;
        logic [SLOT_W-1:0]    digit_slot;
        logic [3:0]           digit_val;
        logic                 neg;
    } t_store_cmd;

    // Slots that a kind must carry for a successful message
    function automatic logic [NUM_SLOTS-1:0] required_mask(input logic [KIND_W-1:0] kind);
        logic [NUM_SLOTS-1:0] m;
        case (kind)
            KIND_DRIVE:   m = 7'h06;
            KIND_SENSOR:  m = 7'h3E;
            KIND_GOAL:    m = 7'h39;
            KIND_SEGMENT: m = 7'h3B;
            default:      m = 7'h00;
        endcase
        return m;
    endfunction

endpackage

[src/vmcp_store.sv]
// Field store of the current record with decimal digit accumulation.
module vmcp_store #(
    parameter int VALUE_BITS = vmcp_pkg::VALUE_BITS_DEF
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_en,
    input  vmcp_pkg::t_store_cmd                               i_cmd,
    output logic [vmcp_pkg::NUM_SLOTS-1:0]                     o_present,
    output logic [vmcp_pkg::NUM_SLOTS-1:0][VALUE_BITS-1:0]     o_field_next
);
    import vmcp_pkg::*;

    localparam int SUM_W = VALUE_BITS + 4;
    localparam logic [VALUE_BITS-1:0] ABSENT = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic [VALUE_BITS-1:0] MAXV   = {1'b0, {(VALUE_BITS-1){1'b1}}};

    logic [NUM_SLOTS-1:0][VALUE_BITS-1:0] r_field;
    logic [NUM_SLOTS-1:0][VALUE_BITS-1:0] n_field;
    logic [VALUE_BITS-1:0]                w_cur;
    logic [VALUE_BITS-1:0]                w_mag;
    logic [SUM_W-1:0]                     w_ext;
    logic [SUM_W-1:0]                     w_prod;
    logic [VALUE_BITS-1:0]                w_sat;
    logic [VALUE_BITS-1:0]                w_digit_res;

    // Select the slot that takes the digit
    always_comb begin
        w_cur = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (i_cmd.digit_slot == SLOT_W'(i)) begin
                w_cur = r_field[i];
            end
        end
    end

    // Shift in one decimal digit, saturate at the largest magnitude
    always_comb begin
        if (w_cur[VALUE_BITS-1]) begin
            w_mag = (w_cur == ABSENT) ? MAXV : (~w_cur + 1'b1);
        end else begin
            w_mag = w_cur;
        end
        w_ext       = {4'b0000, w_mag};
        w_prod      = (w_ext << 3) + (w_ext << 1) + {{(SUM_W-4){1'b0}}, i_cmd.digit_val};
        w_sat       = (w_prod > {4'b0000, MAXV}) ? MAXV : w_prod[VALUE_BITS-1:0];
        w_digit_res = i_cmd.neg ? (~w_sat + 1'b1) : w_sat;
    end

    // Next record and presence flags
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (i_cmd.clear_all) begin
                n_field[i] = ABSENT;
            end else if (i_cmd.zero_mask[i]) begin
                n_field[i] = '0;
            end else if (i_cmd.digit_en && (i_cmd.digit_slot == SLOT_W'(i))) begin
                n_field[i] = w_digit_res;
            end else begin
                n_field[i] = r_field[i];
            end
            o_present[i] = (r_field[i] != ABSENT);
        end
    end

    assign o_field_next = n_field;

    // Hold the record between characters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_field[i] <= ABSENT;
            end
        end else if (i_en) begin
            r_field <= n_field;
        end
    end

endmodule

[src/vmcp_ctrl.sv]
// Parse state machine: decodes each character into a status and a store update.
`include "vehicle_message_char_parser_assert.svh"

module vmcp_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic [7:0]                        i_char,
    input  logic [vmcp_pkg::NUM_SLOTS-1:0]    i_present,
    output logic [vmcp_pkg::STATUS_W-1:0]     o_status,
    output logic [vmcp_pkg::KIND_W-1:0]       o_kind_next,
    output vmcp_pkg::t_store_cmd              o_cmd
);
    import vmcp_pkg::*;

    localparam int STATE_W = 5;
    localparam logic [STATE_W-1:0] ST_KIND        = 5'd0;
    localparam logic [STATE_W-1:0] ST_BRACE       = 5'd1;
    localparam logic [STATE_W-1:0] ST_ATTR        = 5'd2;
    localparam logic [STATE_W-1:0] ST_VAL_FIRST   = 5'd3;
    localparam logic [STATE_W-1:0] ST_NORTH_START = 5'd13;
    localparam logic [STATE_W-1:0] ST_VAL_LAST    = 5'd16;

    logic [STATE_W-1:0] r_state;
    logic [STATE_W-1:0] n_state;
    logic [KIND_W-1:0]  r_kind;
    logic [KIND_W-1:0]  n_kind;
    logic               r_neg;
    logic               n_neg;
    logic [STATUS_W-1:0] w_status;
    t_store_cmd         w_cmd;
    logic               w_ignore;
    logic               w_is_digit;
    logic               w_attr_ok;
    logic [SLOT_W-1:0]  w_attr_slot;
    logic [STATE_W-1:0] w_rel;
    logic [SLOT_W-1:0]  w_slot;
    logic               w_start;
    logic               w_record_ok;

    assign w_ignore   = (i_char == CH_SPACE) || (i_char == CH_TAB) ||
                        (i_char == CH_NUL) || (i_char == CH_CR);
    assign w_is_digit = (i_char >= CH_0) && (i_char <= CH_9);
    assign w_rel      = r_state - ST_VAL_FIRST;
    assign w_slot     = w_rel[SLOT_W:1];
    assign w_start    = ~w_rel[0];
    assign w_record_ok = (r_kind != KIND_NONE) && (r_kind <= KIND_SEGMENT) &&
                         ((required_mask(r_kind) & ~i_present) == '0);

    // Decode the attribute letter into a store slot
    always_comb begin
        w_attr_ok   = 1'b1;
        w_attr_slot = SLOT_NUMBER;
        case (i_char)
            CH_LO_N: w_attr_slot = SLOT_NUMBER;
            CH_LO_S: w_attr_slot = SLOT_SPEED;
            CH_LO_A: w_attr_slot = SLOT_ANGLE;
            CH_LO_B: w_attr_slot = SLOT_BEAR;
            CH_LO_R: w_attr_slot = SLOT_PROB;
            CH_LO_P: w_attr_slot = SLOT_EAST;
            default: w_attr_ok   = 1'b0;
        endcase
    end

    // Work out the next state, status and store update
    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_neg    = r_neg;
        w_status = STAT_OK;
        w_cmd    = '0;
        w_cmd.digit_slot = w_slot;
        w_cmd.digit_val  = i_char[3:0];
        w_cmd.neg        = r_neg;
        if (!w_ignore) begin
            case (r_state)
                ST_KIND: begin
                    w_cmd.clear_all = 1'b1;
                    n_state = ST_BRACE;
                    case (i_char)
                        CH_UP_D: n_kind = KIND_DRIVE;
                        CH_UP_S: n_kind = KIND_SENSOR;
                        CH_UP_G: n_kind = KIND_GOAL;
                        CH_UP_X: n_kind = KIND_SEGMENT;
                        default: begin
                            n_kind   = KIND_NONE;
                            n_state  = ST_KIND;
                            w_status = STAT_BAD_TYPE;
                        end
                    endcase
                end
                ST_BRACE: begin
                    if (i_char == CH_LF) begin
                        n_state  = ST_KIND;
                        w_status = w_record_ok ? STAT_SUCCESS : STAT_INVAL;
                    end else if (i_char == CH_LBRACE) begin
                        n_state = ST_ATTR;
                    end else begin
                        w_status = STAT_BAD_BRACE;
                    end
                end
                ST_ATTR: begin
                    if (w_attr_ok) begin
                        w_cmd.zero_mask[w_attr_slot] = 1'b1;
                        if (w_attr_slot == SLOT_EAST) begin
                            w_cmd.zero_mask[SLOT_NORTH] = 1'b1;
                        end
                        n_neg   = 1'b0;
                        n_state = ST_VAL_FIRST + {1'b0, w_attr_slot, 1'b0};
                    end else begin
                        w_status = STAT_BAD_ATTR;
                    end
                end
                default: begin
                    if ((r_state >= ST_VAL_FIRST) && (r_state <= ST_VAL_LAST)) begin
                        if (w_start && (i_char == CH_MINUS)) begin
                            n_neg   = 1'b1;
                            n_state = r_state + 1'b1;
                        end else begin
                            // A value start falls through to the digit state
                            if (w_start) begin
                                n_state = r_state + 1'b1;
                            end
                            if (w_is_digit) begin
                                w_cmd.digit_en = 1'b1;
                            end else if ((w_slot == SLOT_EAST) && (i_char == CH_COMMA)) begin
                                w_cmd.zero_mask[SLOT_NORTH] = 1'b1;
                                n_neg   = 1'b0;
                                n_state = ST_NORTH_START;
                            end else if ((w_slot != SLOT_EAST) && (i_char == CH_RBRACE)) begin
                                n_state = ST_BRACE;
                            end else begin
                                w_status = STAT_BAD_NUM;
                            end
                        end
                    end
                end
            endcase
        end
    end

    assign o_status    = w_status;
    assign o_kind_next = n_kind;
    assign o_cmd       = w_cmd;

    // Advance the parse state on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_KIND;
            r_kind  <= KIND_NONE;
            r_neg   <= 1'b0;
        end else if (i_en) begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_neg   <= n_neg;
        end
    end

    `VMCP_ASSERT_SAME(a_state_range, i_clk, i_rst_n, 1'b1, r_state <= ST_VAL_LAST, "vmcp: parse state out of range")
    `VMCP_ASSERT_NEXT(a_success_restarts, i_clk, i_rst_n, i_en && (w_status == STAT_SUCCESS), (r_state == ST_KIND) && (r_kind != KIND_NONE), "vmcp: success did not return to kind state")
    `VMCP_ASSERT_NEXT(a_error_holds_state, i_clk, i_rst_n, i_en && ((w_status == STAT_BAD_BRACE) || (w_status == STAT_BAD_ATTR)), (r_state == $past(r_state)) && (r_kind == $past(r_kind)), "vmcp: brace or attribute error changed state")

endmodule

[src/vehicle_message_char_parser.sv]
// Top level of the vehicle message character parser: input stage, parser, result register.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+-------------------------------------------------
//   input   | i_in_valid | o_in_stall  | i_char_in
//   output  | o_out_valid| i_out_stall | o_status, o_msg_kind, seven record fields
//
// One character per cycle while the output is not stalled; a character taken into the
// input register moves on into the result register once that register is free, and its
// result is offered from there.
// The rate is set by the parse state update, which is a single registered step.
// Synchronous active-low reset returns the parser to waiting for a kind letter with
// an empty record.
// With the output stalled, one more character is held in the input register.
`include "vehicle_message_char_parser_assert.svh"

module vehicle_message_char_parser #(
    parameter int VALUE_BITS = vmcp_pkg::VALUE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [7:0]                           i_char_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [vmcp_pkg::STATUS_W-1:0]        o_status,
    output logic [vmcp_pkg::KIND_W-1:0]          o_msg_kind,
    output logic signed [vmcp_pkg::OUT_W-1:0]    o_seq_number,
    output logic signed [vmcp_pkg::OUT_W-1:0]    o_speed_cm_per_s,
    output logic signed [vmcp_pkg::OUT_W-1:0]    o_steer_angle,
    output logic signed [vmcp_pkg::OUT_W-1:0]    o_heading,
    output logic signed [vmcp_pkg::OUT_W-1:0]    o_pos_east,
    output logic signed [vmcp_pkg::OUT_W-1:0]    o_pos_north,
    output logic signed [vmcp_pkg::OUT_W-1:0]    o_likelihood
);
    import vmcp_pkg::*;

    logic                                  r_in_valid;
    logic [7:0]                            r_in_char;
    logic                                  r_out_valid;
    logic [STATUS_W-1:0]                   r_status;
    logic [KIND_W-1:0]                     r_kind;
    logic [NUM_SLOTS-1:0][OUT_W-1:0]       r_field;
    logic                                  w_adv;
    logic                                  w_in_take;
    logic [STATUS_W-1:0]                   w_status;
    logic [KIND_W-1:0]                     w_kind_next;
    t_store_cmd                            w_cmd;
    logic [NUM_SLOTS-1:0]                  w_present;
    logic [NUM_SLOTS-1:0][VALUE_BITS-1:0]  w_field_next;
    logic [NUM_SLOTS-1:0][OUT_W-1:0]       w_field_out;

    // Move the held character into the result register when it is free
    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_in_take  = i_in_valid && !o_in_stall;

    vmcp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_adv),
        .i_char      (r_in_char),
        .i_present   (w_present),
        .o_status    (w_status),
        .o_kind_next (w_kind_next),
        .o_cmd       (w_cmd)
    );

    vmcp_store #(
        .VALUE_BITS (VALUE_BITS)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_adv),
        .i_cmd        (w_cmd),
        .o_present    (w_present),
        .o_field_next (w_field_next)
    );

    // Fit stored values to the 32-bit result fields
    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_fit
        if (VALUE_BITS >= OUT_W) begin : g_trunc
            assign w_field_out[g] = w_field_next[g][OUT_W-1:0];
        end else begin : g_sext
            assign w_field_out[g] = {{(OUT_W-VALUE_BITS){w_field_next[g][VALUE_BITS-1]}},
                                     w_field_next[g]};
        end
    end

    // Input and output valid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture character and result payloads
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_char <= i_char_in;
        end
        if (w_adv) begin
            r_status <= w_status;
            r_kind   <= w_kind_next;
            r_field  <= w_field_out;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_msg_kind       = r_kind;
    assign o_seq_number     = r_field[SLOT_NUMBER];
    assign o_speed_cm_per_s = r_field[SLOT_SPEED];
    assign o_steer_angle    = r_field[SLOT_ANGLE];
    assign o_heading        = r_field[SLOT_BEAR];
    assign o_pos_east       = r_field[SLOT_EAST];
    assign o_pos_north      = r_field[SLOT_NORTH];
    assign o_likelihood     = r_field[SLOT_PROB];

    `VMCP_ASSERT_SAME(a_stall_needs_pending, i_clk, i_rst_n, o_in_stall, r_in_valid && r_out_valid && i_out_stall, "vmcp: input stalled without a held character")
    `VMCP_ASSERT_NEXT(a_adv_fills_output, i_clk, i_rst_n, w_adv, o_out_valid, "vmcp: parsed character produced no result")
    `VMCP_ASSERT_NEXT(a_held_char_kept, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid && $stable(r_in_char), "vmcp: held character lost while output stalled")

endmodule
